// File: hdl/huffman_encoder_bit_packer_macros.svh
// Assertion shorthands for the encoder checker.
`ifndef HUFFMAN_ENCODER_BIT_PACKER_MACROS_SVH
`define HUFFMAN_ENCODER_BIT_PACKER_MACROS_SVH

// Property checked outside reset.
`define HEP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("huffman encoder check failed");

// Property checked on every edge, reset included.
`define HEP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("huffman encoder check failed");

`endif

// File: hdl/hep_pkg.sv
package hep_pkg;

  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int ACC_W  = CODE_W + BYTE_W;
  localparam int CNT_W  = 3;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } sym_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last;
  } byte_beat_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } look_t;

endpackage

// File: hdl/hep_table.sv
module hep_table #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              advance,
  input  hep_pkg::sym_beat_t beat,
  output logic              look_valid,
  output hep_pkg::look_t    look
);

  localparam int AW  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CAP = (MAX_CODE_LEN < hep_pkg::CODE_W) ? MAX_CODE_LEN : hep_pkg::CODE_W;
  localparam int LW  = $clog2(CAP + 1);

  logic [hep_pkg::CODE_W-1:0] code_mem [NUM_SYMBOLS];
  logic [LW-1:0]              len_mem  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]     valid;

  logic [AW-1:0]              addr;
  logic                       hit;
  logic                       wr_en;
  logic [LW-1:0]              sat_len;

  logic [1:0]                 mode;
  logic [hep_pkg::CODE_W-1:0] code_q;
  logic [LW-1:0]              len_q;
  logic                       vbit;

  assign addr    = beat.symbol[AW-1:0];
  assign hit     = {1'b0, beat.symbol} < 9'(NUM_SYMBOLS);
  assign wr_en   = accept && (beat.mode == hep_pkg::MODE_LOAD) && hit;
  assign sat_len = (beat.code_length > hep_pkg::LEN_W'(CAP)) ? LW'(CAP)
                                                             : beat.code_length[LW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[addr] <= beat.code_word;
      len_mem[addr]  <= sat_len;
    end
    if (accept) begin
      code_q <= code_mem[addr];
      len_q  <= len_mem[addr];
      mode   <= beat.mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      vbit       <= 1'b0;
      look_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[addr] <= 1'b1;
      end
      if (accept) begin
        vbit       <= valid[addr] && hit;
        look_valid <= 1'b1;
      end else if (advance) begin
        look_valid <= 1'b0;
      end
    end
  end

  // unwritten or out-of-range entries read as length zero
  assign look.mode = mode;
  assign look.code = code_q;
  assign look.len  = vbit ? hep_pkg::LEN_W'(len_q) : '0;

endmodule

// File: hdl/hep_packer.sv
module hep_packer (
  input  logic                clk,
  input  logic                rst,
  input  logic                look_valid,
  input  hep_pkg::look_t      look,
  output logic                advance,
  output logic                byte_valid,
  input  logic                byte_stall,
  output hep_pkg::byte_beat_t byte_data
);

  logic [hep_pkg::BYTE_W-1:0] pend_bits, pend_bits_next;
  logic [2:0]                 pend_count, pend_count_next;
  logic [hep_pkg::CNT_W-1:0]  cnt;
  logic [hep_pkg::ACC_W-1:0]  shreg;

  logic [hep_pkg::ACC_W-1:0]  aligned, acc, rest, load_val;
  logic [hep_pkg::LEN_W-1:0]  total;
  logic [hep_pkg::CNT_W-1:0]  enc_n, n;
  logic                       free, fire;

  // code left-aligned below the pending bits
  assign aligned = ({look.code, hep_pkg::BYTE_W'(0)}
                    << (hep_pkg::LEN_W'(hep_pkg::CODE_W) - look.len)) >> pend_count;
  assign acc     = {pend_bits, hep_pkg::CODE_W'(0)} | aligned;
  assign total   = hep_pkg::LEN_W'(pend_count) + look.len;
  assign enc_n   = hep_pkg::CNT_W'(total[hep_pkg::LEN_W-1:3]);
  assign rest    = acc << {enc_n, 3'b000};

  always_comb begin
    n               = '0;
    load_val        = acc;
    pend_bits_next  = pend_bits;
    pend_count_next = pend_count;
    case (look.mode)
      hep_pkg::MODE_ENCODE: begin
        n               = enc_n;
        pend_bits_next  = rest[hep_pkg::ACC_W-1 -: hep_pkg::BYTE_W];
        pend_count_next = total[2:0];
      end
      hep_pkg::MODE_FLUSH: begin
        n               = (pend_count != 3'd0) ? hep_pkg::CNT_W'(1) : '0;
        load_val        = {pend_bits, hep_pkg::CODE_W'(0)};
        pend_bits_next  = '0;
        pend_count_next = 3'd0;
      end
      default: begin
        n = '0;
      end
    endcase
  end

  assign fire    = (cnt != '0) && !byte_stall;
  assign free    = (cnt == '0) || ((cnt == hep_pkg::CNT_W'(1)) && !byte_stall);
  assign advance = look_valid && ((n == '0) || free);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pend_bits  <= '0;
      pend_count <= 3'd0;
    end else begin
      if (advance) begin
        pend_bits  <= pend_bits_next;
        pend_count <= pend_count_next;
      end
      if (advance && (n != '0)) begin
        cnt <= n;
      end else if (fire) begin
        cnt <= cnt - hep_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (n != '0)) begin
      shreg <= load_val;
    end else if (fire) begin
      shreg <= shreg << hep_pkg::BYTE_W;
    end
  end

  assign byte_valid            = cnt != '0;
  assign byte_data.packed_byte = shreg[hep_pkg::ACC_W-1 -: hep_pkg::BYTE_W];
  assign byte_data.last        = cnt == hep_pkg::CNT_W'(1);

endmodule

// File: hdl/huffman_encoder_bit_packer.sv
// An accepted beat is registered in the table, then its bytes load the byte shifter.
// Throughput: one beat per cycle while the byte shifter is free; an encode yielding n
// bytes (n up to 4) holds the byte shifter until all have left, so it sets the rate.
// Reset: length valid bits, pending bits and the byte shifter count clear;
// code table contents stay undefined until loaded. No clearing pass.
module huffman_encoder_bit_packer #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS  = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                sym_valid,
  output logic                sym_stall,
  input  hep_pkg::sym_beat_t  sym_data,
  output logic                byte_valid,
  input  logic                byte_stall,
  output hep_pkg::byte_beat_t byte_data
);

  logic           accept;
  logic           advance;
  logic           look_valid;
  hep_pkg::look_t look;

  assign sym_stall = look_valid && !advance;
  assign accept    = sym_valid && !sym_stall;

  hep_table #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .advance   (advance),
    .beat      (sym_data),
    .look_valid(look_valid),
    .look      (look)
  );

  hep_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .look_valid(look_valid),
    .look      (look),
    .advance   (advance),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_data (byte_data)
  );

endmodule

// File: hdl/hep_checker.sv
`include "huffman_encoder_bit_packer_macros.svh"

module hep_checker (
  input logic                clk,
  input logic                rst,
  input logic                sym_valid,
  input logic                sym_stall,
  input hep_pkg::sym_beat_t  sym_data,
  input logic                byte_valid,
  input logic                byte_stall,
  input hep_pkg::byte_beat_t byte_data
);

  // stalled byte beat holds
  `HEP_ASSERT(a_byte_hold, clk, rst, byte_valid && byte_stall |=> byte_valid && $stable(byte_data))

  // output empty straight after reset
  `HEP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !byte_valid)

  // bytes of one symbol leave back to back
  `HEP_ASSERT(a_burst_cont, clk, rst, byte_valid && !byte_stall && !byte_data.last |=> byte_valid)

  // with the shifter empty the input is never held off
  `HEP_ASSERT(a_no_idle_stall, clk, rst, !byte_valid |-> !sym_stall)

endmodule

bind huffman_encoder_bit_packer hep_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .sym_valid (sym_valid),
  .sym_stall (sym_stall),
  .sym_data  (sym_data),
  .byte_valid(byte_valid),
  .byte_stall(byte_stall),
  .byte_data (byte_data)
);
